@@ design/modbus_frame_crc_checker_core_assert.svh @@
// Assertion macros shared by the Modbus frame CRC checker modules.
`ifndef MODBUS_FRAME_CRC_CHECKER_CORE_ASSERT_SVH
`define MODBUS_FRAME_CRC_CHECKER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MBCRC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define MBCRC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/mbcrc_pkg.sv @@
// Shared types, constants and the CRC byte update for the Modbus frame CRC checker.
package mbcrc_pkg;

  localparam int MAX_FRAME_BYTES = 255;
  localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 2);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic FUNC_DATA = 1'b0;
  localparam logic FUNC_EOF  = 1'b1;

  localparam logic [1:0] ST_MISMATCH = 2'd0;
  localparam logic [1:0] ST_MATCH    = 2'd1;
  localparam logic [1:0] ST_NOFRAME  = 2'd2;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic       eof;
    logic [7:0] data;
  } item_t;

  // Queue handshake between front and back.
  typedef struct packed {
    logic  push;
    item_t push_item;
    logic  pop;
  } q_ctrl_t;

  typedef struct packed {
    logic  full;
    logic  empty;
    item_t head;
  } q_stat_t;

  // One byte of CRC-16/MODBUS, reflected, LSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ design/mbcrc_front.sv @@
// Input stage: accepts stream transactions and classifies them into queue items.
module mbcrc_front
  import mbcrc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic [0:0] in_tuser,
  input  logic       q_full,
  output logic       q_push,
  output item_t      q_item
);

  logic  vld_r, vld_nxt;
  item_t item_r;
  logic  in_acc;

  assign q_push    = vld_r && !q_full;
  assign in_tready = !vld_r || !q_full;
  assign in_acc    = in_tvalid && in_tready;
  assign q_item    = item_r;

  always_comb begin
    vld_nxt = vld_r;
    if (in_acc) begin
      vld_nxt = 1'b1;
    end else if (q_push) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r.eof  <= (in_tuser[0] == FUNC_EOF);
      item_r.data <= in_tdata;
    end
  end

endmodule

@@ design/mbcrc_queue.sv @@
// Short queue between the input stage and the CRC engine.
`include "modbus_frame_crc_checker_core_assert.svh"
module mbcrc_queue
  import mbcrc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  q_ctrl_t ctrl,
  output q_stat_t stat
);

  item_t          mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           push, pop;

  assign stat.full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign stat.head  = mem_r[rd_ptr_r];

  assign push = ctrl.push && !stat.full;
  assign pop  = ctrl.pop && !stat.empty;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + (QAW+1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (QAW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= ctrl.push_item;
    end
  end

  `MBCRC_ASSERT_IMP(a_q_cnt_bound, 1'b1, cnt_r <= (QAW+1)'(QDEPTH), "queue count over depth")
  `MBCRC_ASSERT_NXT(a_q_cnt_up, push && !pop, cnt_r == $past(cnt_r) + (QAW+1)'(1), "queue count did not grow")
  `MBCRC_ASSERT_IMP(a_q_ptr_gap, 1'b1, (wr_ptr_r - rd_ptr_r) == cnt_r[QAW-1:0], "queue pointers disagree with count")

endmodule

@@ design/mbcrc_back.sv @@
// CRC engine: folds delayed bytes into the running CRC and registers frame status.
`include "modbus_frame_crc_checker_core_assert.svh"
module mbcrc_back
  import mbcrc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  item_t      q_head,
  output logic       q_pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata
);

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME_BYTES);

  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       held0_r, held1_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_vld_r, out_vld_nxt;
  logic [1:0]       status_r, status_calc;
  logic [15:0]      crc_cmp;
  logic             pop_eof, pop_data;

  assign q_pop    = !q_empty && (!q_head.eof || !out_vld_r || out_tready);
  assign pop_eof  = q_pop && q_head.eof;
  assign pop_data = q_pop && !q_head.eof;

  // With exactly two bytes held the CRC has not absorbed byte 0 yet.
  assign crc_cmp = (cnt_r == CNT_W'(2)) ? crc_byte(crc_r, held0_r) : crc_r;

  always_comb begin
    if (cnt_r == '0 || cnt_r > MAX_CNT) begin
      status_calc = ST_NOFRAME;
    end else if (cnt_r == CNT_W'(1)) begin
      status_calc = ST_MISMATCH;
    end else if (held0_r == crc_cmp[7:0] && held1_r == crc_cmp[15:8]) begin
      status_calc = ST_MATCH;
    end else begin
      status_calc = ST_MISMATCH;
    end
  end

  always_comb begin
    crc_nxt = crc_r;
    cnt_nxt = cnt_r;
    if (pop_eof) begin
      crc_nxt = CRC_INIT;
      cnt_nxt = '0;
    end else if (pop_data) begin
      if (cnt_r >= CNT_W'(2)) begin
        crc_nxt = crc_byte(crc_r, held0_r);
      end
      if (cnt_r <= MAX_CNT) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
    out_vld_nxt = out_vld_r && !out_tready;
    if (pop_eof) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r     <= CRC_INIT;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      crc_r     <= crc_nxt;
      cnt_r     <= cnt_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_data) begin
      held0_r <= held1_r;
      held1_r <= q_head.data;
    end
    if (pop_eof) begin
      status_r <= status_calc;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, status_r};

  `MBCRC_ASSERT_NXT(a_eof_clears, pop_eof, cnt_r == '0 && crc_r == CRC_INIT, "state not cleared after end of frame")
  `MBCRC_ASSERT_NXT(a_eof_shows, pop_eof, out_vld_r, "end of frame gave no status")
  `MBCRC_ASSERT_IMP(a_cnt_sat, 1'b1, cnt_r <= MAX_CNT + CNT_W'(1), "byte count beyond saturation")
  `MBCRC_ASSERT_IMP(a_status_code, out_vld_r, status_r != 2'd3, "undefined status code")

endmodule

@@ design/modbus_frame_crc_checker_core.sv @@
// Top level of the Modbus RTU reply frame CRC checker.
//
// Input channel (in_*): one transaction per received frame byte. in_tuser[0] is the
// function flag: 0 carries a data byte in in_tdata, 1 marks the end of the frame (data
// ignored). Result channel (out_*): one transaction per end-of-frame marker, with the
// frame status in out_tdata[1:0]: 0 CRC mismatch, 1 CRC match, 2 empty or overlong.
// The CRC is CRC-16/MODBUS over all bytes but the last two, the transmitted CRC (low
// byte first); a two-byte frame is compared with its first byte's CRC. Frames longer
// than MAX_FRAME_BYTES report status 2.
// Throughput is one transaction per cycle while no end-of-frame marker waits on a
// stalled status: the CRC engine folds one byte per cycle with an unrolled byte-wide
// update. With an empty queue, an end-of-frame marker passes the input register and
// the queue before its status is registered and raised on out_tvalid.
// When the receiver stalls, the status register holds and the queue between the input
// stage and the CRC engine keeps absorbing data bytes; in_tready falls only once the
// four-entry queue and the input register are full. Data bytes keep flowing past a
// stalled status; only the next end-of-frame marker waits for the status register.
// A synchronous active-low reset empties the queue, drops any pending status and
// returns the CRC to 0xFFFF with a zero byte count.
module modbus_frame_crc_checker_core
  import mbcrc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic [0:0] in_tuser,   // [0] func
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [1:0] frame_status, [7:2] zero
);

  q_ctrl_t q_ctrl;
  q_stat_t q_stat;
  logic    q_push;
  logic    q_pop;
  item_t   q_item;

  // The queue controls come from both sides and are gathered here in one place.
  assign q_ctrl = '{push: q_push, push_item: q_item, pop: q_pop};

  // Input stage classifies each transaction into a data or end-of-frame item.
  mbcrc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_stat.full),
    .q_push    (q_push),
    .q_item    (q_item)
  );

  // The queue lets the input stage run ahead while a status waits to be taken.
  mbcrc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (q_ctrl),
    .stat  (q_stat)
  );

  // CRC engine and status output register.
  mbcrc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_stat.empty),
    .q_head     (q_stat.head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

@@ bench/mbcrc_frame_scoreboard.sv @@
// Scoreboard for the Modbus frame CRC checker: predicts each frame status and checks the result channel.
package mbcrc_tb_pkg;

  import mbcrc_pkg::*;

  // Feeds one octet into a CRC-16/MODBUS accumulator bit by bit, least significant bit first.
  function automatic logic [15:0] modbus_crc_fold(input logic [15:0] acc, input logic [7:0] octet);
    logic low_bit;
    for (int i = 0; i < 8; i++) begin
      low_bit = acc[0] ^ octet[i];
      acc = acc >> 1;
      if (low_bit) begin
        acc = acc ^ CRC_POLY;
      end
    end
    return acc;
  endfunction

endpackage

module mbcrc_frame_scoreboard
  import mbcrc_pkg::*;
  import mbcrc_tb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic [0:0] in_tuser,
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,
  output int         fail_count,
  output int         pending
);

  logic [1:0]       status_q[$];
  logic [15:0]      crc_acc;
  logic [7:0]       older_byte;
  logic [7:0]       newer_byte;
  logic [CNT_W-1:0] byte_total;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
    fail_count++;
    $display("%0t: %s: expected %02h, got %02h", $time, what, want, got);
  endtask

  task automatic clear_frame();
    crc_acc    = CRC_INIT;
    older_byte = 8'h00;
    newer_byte = 8'h00;
    byte_total = '0;
  endtask

  always @(posedge clk) begin : observe
    logic [15:0] frame_crc;
    logic [1:0]  want;
    if (!rst_n) begin
      clear_frame();
      status_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (status_q.size() == 0) begin
          report_mismatch("status with no frame closed", 8'h00, out_tdata);
        end else begin
          want = status_q.pop_front();
          if (out_tdata[1:0] !== want) begin
            report_mismatch("frame_status", {6'b0, want}, {6'b0, out_tdata[1:0]});
          end
          if (out_tdata[7:2] !== 6'b0) begin
            report_mismatch("status padding bits", 8'h00, {2'b0, out_tdata[7:2]});
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser[0] == FUNC_DATA) begin
          // A byte enters the CRC only after two newer bytes have pushed it out.
          if (byte_total >= 2) begin
            crc_acc = modbus_crc_fold(crc_acc, older_byte);
          end
          older_byte = newer_byte;
          newer_byte = in_tdata;
          if (byte_total <= MAX_FRAME_BYTES) begin
            byte_total = byte_total + 1'b1;
          end
        end else begin
          if (byte_total == 0 || byte_total > MAX_FRAME_BYTES) begin
            want = ST_NOFRAME;
          end else if (byte_total == 1) begin
            want = ST_MISMATCH;
          end else begin
            // With only two bytes, the first byte's own CRC is checked against both.
            frame_crc = (byte_total == 2) ? modbus_crc_fold(CRC_INIT, older_byte) : crc_acc;
            want = ({newer_byte, older_byte} == frame_crc) ? ST_MATCH : ST_MISMATCH;
          end
          status_q.push_back(want);
          clear_frame();
        end
      end
    end
    pending = status_q.size();
  end

endmodule

@@ bench/tb.sv @@
// Testbench top for the Modbus frame CRC checker: clock, reset, frame stimulus and verdict.
module tb
  import mbcrc_pkg::*, mbcrc_tb_pkg::*;
();

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic [7:0] in_tdata   = 8'h00;
  logic [0:0] in_tuser   = FUNC_DATA;
  logic       out_tready = 1'b0;
  logic       in_tready;
  logic       out_tvalid;
  logic [7:0] out_tdata;

  int fail_count;
  int pending;

  int         burst_left = 0;
  int         items_sent = 0;
  int         ready_run  = 0;
  logic [7:0] frame_bytes[$];
  logic       quirk_ok   = 1'b0;
  logic [7:0] quirk_lo;
  logic [7:0] quirk_hi;

  modbus_frame_crc_checker_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  mbcrc_frame_scoreboard u_scoreboard (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver goes through ready runs and stall runs of random length, each kind picked at random.
  always @(negedge clk) begin
    if (ready_run == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        ready_run = $urandom_range(1, 7);
      end else begin
        out_tready <= 1'b1;
        ready_run = $urandom_range(1, 40);
      end
    end else begin
      ready_run--;
    end
  end

  // Offers one transaction and holds it until the handshake completes.
  task automatic send_item(input logic func, input logic [7:0] octet);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        in_tdata  <= 8'($urandom);
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= octet;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    items_sent++;
  endtask

  // Sends the bytes held in frame_bytes, then the end-of-frame marker with junk data.
  task automatic send_frame();
    foreach (frame_bytes[i]) send_item(FUNC_DATA, frame_bytes[i]);
    send_item(FUNC_EOF, 8'($urandom));
  endtask

  task automatic fill_random(input int count);
    frame_bytes.delete();
    repeat (count) frame_bytes.push_back(8'($urandom));
  endtask

  // Appends the CRC of the current bytes, low byte first, as a sender would.
  task automatic seal_frame();
    logic [15:0] c;
    c = CRC_INIT;
    foreach (frame_bytes[i]) c = modbus_crc_fold(c, frame_bytes[i]);
    frame_bytes.push_back(c[7:0]);
    frame_bytes.push_back(c[15:8]);
  endtask

  // Drops valid, then waits until every status has come out.
  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    logic [15:0] c;
    int          kind;
    int          idx;
    int          start_count;
    logic        paused;

    // Look for a byte whose own CRC low byte equals itself, which makes a two-byte frame match.
    for (int b = 0; b < 256; b++) begin
      c = modbus_crc_fold(CRC_INIT, 8'(b));
      if (!quirk_ok && c[7:0] == 8'(b)) begin
        quirk_ok = 1'b1;
        quirk_lo = 8'(b);
        quirk_hi = c[15:8];
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty frames, back to back.
    frame_bytes.delete();
    send_frame();
    send_frame();
    // One-byte frame.
    frame_bytes = {8'h00};
    send_frame();
    // Two-byte frames, a plain one and, if such a byte exists, one that matches.
    frame_bytes = {8'hFF, 8'h00};
    send_frame();
    if (quirk_ok) begin
      frame_bytes = {quirk_lo, quirk_hi};
      send_frame();
    end
    // Shortest sealed frames at the byte extremes.
    frame_bytes = {8'h00};
    seal_frame();
    send_frame();
    frame_bytes = {8'hFF, 8'hFF};
    seal_frame();
    send_frame();
    // A typical holding-register reply, then the same with its CRC high byte inverted.
    frame_bytes = {8'h01, 8'h03, 8'h02, 8'h00, 8'h0A};
    seal_frame();
    send_frame();
    frame_bytes[$] = ~frame_bytes[$];
    send_frame();
    // Longest allowed frame, then one that is a byte over the limit.
    fill_random(MAX_FRAME_BYTES - 2);
    seal_frame();
    send_frame();
    fill_random(MAX_FRAME_BYTES + 1);
    send_frame();

    hold_until_drained();

    start_count = items_sent;
    paused      = 1'b0;
    while (items_sent - start_count < 100) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        fill_random($urandom_range(1, 10));
        seal_frame();
      end else if (kind < 85) begin
        fill_random($urandom_range(1, 10));
        seal_frame();
        idx = $urandom_range(0, frame_bytes.size() - 1);
        frame_bytes[idx] = frame_bytes[idx] ^ 8'(1 << $urandom_range(0, 7));
      end else if (kind < 89) begin
        frame_bytes.delete();
      end else if (kind < 92) begin
        fill_random(1);
      end else if (kind < 96) begin
        if (quirk_ok && $urandom_range(0, 1) == 0) begin
          frame_bytes = {quirk_lo, quirk_hi};
        end else begin
          fill_random(2);
        end
      end else if (kind < 99) begin
        fill_random($urandom_range(3, 12));
      end else begin
        fill_random($urandom_range(MAX_FRAME_BYTES + 1, MAX_FRAME_BYTES + 15));
      end
      send_frame();
      if (!paused && items_sent - start_count > 50) begin
        hold_until_drained();
        paused = 1'b1;
      end
    end

    hold_until_drained();
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("modbus_frame_crc_checker_core: match");
    end else begin
      $display("modbus_frame_crc_checker_core: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("modbus_frame_crc_checker_core: mismatch");
    $finish;
  end

endmodule
